### rtl/core/knnl_pkg.sv
// ----------------------------------------------------------------------------
// knnl_pkg
// Shared constants, codes and control types of the nearest neighbor list.
// ----------------------------------------------------------------------------
package knnl_pkg;

    // List storage.
    localparam int LIST_DEPTH = 16;
    localparam int ID_BITS    = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Field widths.
    localparam int CMD_W      = 2;
    localparam int ID_W       = 16;
    localparam int POS_W      = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 2 * POS_W + 1;
    localparam int SUM_W      = SQ_W + 1;
    localparam int DIST_W     = 36;
    localparam int SLOT_W     = 4;
    localparam int HELD_W     = 5;
    localparam int KEEP_W     = 5;
    localparam int CAP_W      = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ID    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT  = 3'd4;

    localparam logic [DIST_W-1:0] RANGE_RESET = 36'h8_0000_0000;
    localparam logic [KEEP_W-1:0] KEEP_RESET  = 5'd16;

    // Command codes of an input word.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFFER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // capture candidate, form coordinate differences
        logic clear;       // empty the list, reload the range
        logic square;      // square the differences
        logic insert;      // compare against all slots, shift and place
        logic range_upd;   // shrink the range to the farthest entry if accepted and full
        logic rd_start;    // rewind the read-out index
        logic emit_status; // load a status word into the output register
        logic emit_entry;  // load a list word into the output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;    // output register can take a word this cycle
        logic list_empty;  // no entries held
        logic rd_last;     // read-out index points at the last entry
    } t_dp_stat;

endpackage

### rtl/core/k_nearest_neighbor_list.sv
// ----------------------------------------------------------------------------
// k_nearest_neighbor_list
// Keeps the nearest candidates to a query point, sorted by squared distance.
// ----------------------------------------------------------------------------
// The block holds up to keep_count (at most 16) candidates nearest to the
// query point, in ascending order of squared distance, ties kept in arrival
// order. Each input word carries a command. A clear empties the list and loads
// the search range from start_range_sq; its status word is then loaded in the
// emit state. An offer forms the coordinate differences at the edge that
// accepts it and then passes through the square state, which registers the
// results of the two 17 by 17 squaring multipliers, the insert state, in which
// the summed distance is compared against every slot at once and the list
// shifts to open the insert slot, the range state, in which the range shrinks
// to the farthest entry if the offer was accepted and the list is full, and
// the emit state, which loads its status word; the input stays stalled
// throughout. A read streams one word per cycle while the output register is
// not stalled, one for each entry held (one word when empty). The sequencer
// handles one word at a time; stall on the input stays high until the last
// result of the word has been loaded into the output register, which then
// waits on its own while the next word is taken. A full output register that
// is stalled holds the emit and read states. Command code 3 is accepted and
// produces no result. Distances are exact: positions are signed 8.8 fixed
// point, squared distances carry 16 fraction bits. Offers from the query's own
// id are ignored. Configuration is written through a plain write port; the
// user must write it only while the block is idle, not enforced by the block.
// ----------------------------------------------------------------------------
module k_nearest_neighbor_list (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [knnl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [knnl_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    // Input words.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [knnl_pkg::CMD_W-1:0]           i_cmd,
    input  logic [knnl_pkg::ID_W-1:0]            i_cand_id,
    input  logic signed [knnl_pkg::POS_W-1:0]    i_cand_x,
    input  logic signed [knnl_pkg::POS_W-1:0]    i_cand_y,

    // Result words.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_accepted,
    output logic [knnl_pkg::SLOT_W-1:0]          o_slot,
    output logic [knnl_pkg::HELD_W-1:0]          o_held,
    output logic [knnl_pkg::DIST_W-1:0]          o_range_now,
    output logic [knnl_pkg::ID_W-1:0]            o_entry_id,
    output logic [knnl_pkg::DIST_W-1:0]          o_entry_dist_sq,
    output logic                                 o_last
);
    import knnl_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    t_dp_cmd  dp_ctl;
    t_dp_stat dp_stat;

    knnl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_ctl      (dp_ctl)
    );

    // The datapath holds the list as a row of slot registers; every slot
    // compares itself with the new distance in the same cycle; the insert slot
    // takes the new entry and each later slot takes its preceding neighbor's contents.
    knnl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cand_id       (i_cand_id),
        .i_cand_x        (i_cand_x),
        .i_cand_y        (i_cand_y),
        .i_ctl           (dp_ctl),
        .o_stat          (dp_stat),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_accepted      (o_accepted),
        .o_slot          (o_slot),
        .o_held          (o_held),
        .o_range_now     (o_range_now),
        .o_entry_id      (o_entry_id),
        .o_entry_dist_sq (o_entry_dist_sq),
        .o_last          (o_last)
    );

endmodule

### rtl/core/knnl_dp.sv
// ----------------------------------------------------------------------------
// knnl_dp
// Datapath: configuration registers, distance arithmetic, the sorted list
// with parallel compare-and-shift insertion, and the output register.
// ----------------------------------------------------------------------------
module knnl_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [knnl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [knnl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [knnl_pkg::ID_W-1:0]            i_cand_id,
    input  logic signed [knnl_pkg::POS_W-1:0]    i_cand_x,
    input  logic signed [knnl_pkg::POS_W-1:0]    i_cand_y,
    input  knnl_pkg::t_dp_cmd                    i_ctl,
    output knnl_pkg::t_dp_stat                   o_stat,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_accepted,
    output logic [knnl_pkg::SLOT_W-1:0]          o_slot,
    output logic [knnl_pkg::HELD_W-1:0]          o_held,
    output logic [knnl_pkg::DIST_W-1:0]          o_range_now,
    output logic [knnl_pkg::ID_W-1:0]            o_entry_id,
    output logic [knnl_pkg::DIST_W-1:0]          o_entry_dist_sq,
    output logic                                 o_last
);
    import knnl_pkg::*;

    // Configuration.
    logic [ID_W-1:0]          r_qid;
    logic signed [POS_W-1:0]  r_qx;
    logic signed [POS_W-1:0]  r_qy;
    logic [DIST_W-1:0]        r_start;
    logic [KEEP_W-1:0]        r_keep;

    // Item in flight.
    logic [ID_BITS-1:0]       r_cid;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [SQ_W-1:0]          r_sqx;
    logic [SQ_W-1:0]          r_sqy;

    // List and its control state.
    logic [DIST_W-1:0]        r_dist [LIST_DEPTH];
    logic [ID_BITS-1:0]       r_id   [LIST_DEPTH];
    logic [CNT_W-1:0]         r_fill;
    logic [DIST_W-1:0]        r_range;
    logic                     r_acc;
    logic [IDX_W-1:0]         r_slot;
    logic [IDX_W-1:0]         r_rd_idx;

    // Output register.
    logic                     r_out_valid;
    logic                     r_o_acc;
    logic [SLOT_W-1:0]        r_o_slot;
    logic [HELD_W-1:0]        r_o_held;
    logic [DIST_W-1:0]        r_o_range;
    logic [ID_W-1:0]          r_o_eid;
    logic [DIST_W-1:0]        r_o_edist;
    logic                     r_o_last;

    logic signed [2*DIFF_W-1:0] prod_x;
    logic signed [2*DIFF_W-1:0] prod_y;
    logic [SUM_W-1:0]         d_sum;
    logic [DIST_W-1:0]        d_new;
    logic [CAP_W-1:0]         keep_ext;
    logic [CAP_W-1:0]         cap_sat;
    logic [CNT_W-1:0]         cap;
    logic [CNT_W-1:0]         fill_m1;
    logic [CNT_W-1:0]         limit;
    logic                     can_append;
    logic                     ins_ok;
    logic [LIST_DEPTH-1:0]    lt;
    logic [LIST_DEPTH-1:0]    ge;
    logic [IDX_W-1:0]         pos;
    logic [DIST_W-1:0]        src_dist [LIST_DEPTH];
    logic [ID_BITS-1:0]       src_id   [LIST_DEPTH];
    logic [IDX_W-1:0]         rd_addr;
    logic [DIST_W-1:0]        rd_dist;
    logic                     out_free;

    assign prod_x = r_dx * r_dx;
    assign prod_y = r_dy * r_dy;

    assign d_sum = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign d_new = DIST_W'(d_sum);

    assign keep_ext = CAP_W'(r_keep);
    assign cap_sat  = (keep_ext > CAP_W'(LIST_DEPTH)) ? CAP_W'(LIST_DEPTH) : keep_ext;
    assign cap      = CNT_W'(cap_sat);

    assign fill_m1    = r_fill - CNT_W'(1);
    assign can_append = (r_fill < cap);
    assign limit      = can_append ? r_fill : fill_m1;

    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            lt[i] = (d_new < r_dist[i]);
            ge[i] = (CNT_W'(i) >= limit) | lt[i];
        end
    end

    // The list is sorted, so ge is a run of ones starting at the insert slot.
    always_comb begin
        pos = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (ge[i]) begin
                pos = IDX_W'(i);
            end
        end
    end

    assign ins_ok = (cap != '0) && (r_cid != ID_BITS'(r_qid)) && (d_new < r_range)
                    && (can_append || lt[fill_m1[IDX_W-1:0]]);

    always_comb begin
        src_dist[0] = d_new;
        src_id[0]   = r_cid;
        for (int i = 1; i < LIST_DEPTH; i++) begin
            src_dist[i] = ge[i-1] ? r_dist[i-1] : d_new;
            src_id[i]   = ge[i-1] ? r_id[i-1]   : r_cid;
        end
    end

    // Single read port, shared by range update and read-out.
    assign rd_addr = i_ctl.range_upd ? fill_m1[IDX_W-1:0] : r_rd_idx;
    assign rd_dist = r_dist[rd_addr];

    assign out_free          = !r_out_valid || !i_out_stall;
    assign o_stat.out_free   = out_free;
    assign o_stat.list_empty = (r_fill == '0);
    assign o_stat.rd_last    = (CNT_W'(r_rd_idx) == fill_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qid   <= '0;
            r_qx    <= '0;
            r_qy    <= '0;
            r_start <= RANGE_RESET;
            r_keep  <= KEEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUERY_ID:    r_qid   <= i_cfg_data[ID_W-1:0];
                CFG_QUERY_X:     r_qx    <= i_cfg_data[POS_W-1:0];
                CFG_QUERY_Y:     r_qy    <= i_cfg_data[POS_W-1:0];
                CFG_START_RANGE: r_start <= i_cfg_data[DIST_W-1:0];
                CFG_KEEP_COUNT:  r_keep  <= i_cfg_data[KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cid <= ID_BITS'(i_cand_id);
            r_dx  <= {i_cand_x[POS_W-1], i_cand_x} - {r_qx[POS_W-1], r_qx};
            r_dy  <= {i_cand_y[POS_W-1], i_cand_y} - {r_qy[POS_W-1], r_qy};
        end
        if (i_ctl.square) begin
            r_sqx <= prod_x[SQ_W-1:0];
            r_sqy <= prod_y[SQ_W-1:0];
        end
        if (i_ctl.insert && ins_ok) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
                if (ge[i] && (CNT_W'(i) <= limit)) begin
                    r_dist[i] <= src_dist[i];
                    r_id[i]   <= src_id[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_range  <= RANGE_RESET;
            r_acc    <= 1'b0;
            r_slot   <= '0;
            r_rd_idx <= '0;
        end else begin
            if (i_ctl.clear) begin
                r_fill  <= '0;
                r_range <= r_start;
                r_acc   <= 1'b0;
                r_slot  <= '0;
            end
            if (i_ctl.insert) begin
                r_acc  <= ins_ok;
                r_slot <= ins_ok ? pos : '0;
                if (ins_ok && can_append) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (i_ctl.range_upd && r_acc && (r_fill >= cap)) begin
                r_range <= rd_dist;
            end
            if (i_ctl.rd_start) begin
                r_rd_idx <= '0;
            end else if (i_ctl.emit_entry) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit_status || i_ctl.emit_entry) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_status) begin
            r_o_acc   <= r_acc;
            r_o_slot  <= SLOT_W'(r_slot);
            r_o_held  <= HELD_W'(r_fill);
            r_o_range <= r_range;
            r_o_eid   <= '0;
            r_o_edist <= '0;
            r_o_last  <= 1'b1;
        end else if (i_ctl.emit_entry) begin
            r_o_acc   <= 1'b0;
            r_o_held  <= HELD_W'(r_fill);
            r_o_range <= r_range;
            if (r_fill == '0) begin
                r_o_slot  <= '0;
                r_o_eid   <= '0;
                r_o_edist <= '0;
                r_o_last  <= 1'b1;
            end else begin
                r_o_slot  <= SLOT_W'(r_rd_idx);
                r_o_eid   <= ID_W'(r_id[r_rd_idx]);
                r_o_edist <= rd_dist;
                r_o_last  <= o_stat.rd_last;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_o_acc;
    assign o_slot          = r_o_slot;
    assign o_held          = r_o_held;
    assign o_range_now     = r_o_range;
    assign o_entry_id      = r_o_eid;
    assign o_entry_dist_sq = r_o_edist;
    assign o_last          = r_o_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(LIST_DEPTH))
        else $error("list fill count beyond depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.emit_status || i_ctl.emit_entry) |-> out_free)
        else $error("output word loaded over a pending word");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_fill == '0 && r_range == $past(r_start)))
        else $error("clear did not empty list and reload range");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.insert |=> (r_fill >= $past(r_fill)))
        else $error("insertion shrank the list");

endmodule

### rtl/core/knnl_ctrl.sv
// ----------------------------------------------------------------------------
// knnl_ctrl
// Sequencer: steps each input word through the datapath and paces results.
// ----------------------------------------------------------------------------
module knnl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [knnl_pkg::CMD_W-1:0]    i_cmd,
    output logic                          o_in_stall,
    input  knnl_pkg::t_dp_stat            i_stat,
    output knnl_pkg::t_dp_cmd             o_ctl
);
    import knnl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_INSERT,
        ST_RANGE,
        ST_EMIT,
        ST_READ
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_CLEAR: begin
                            o_ctl.clear = 1'b1;
                            n_state     = ST_EMIT;
                        end
                        CMD_OFFER: begin
                            o_ctl.load = 1'b1;
                            n_state    = ST_SQUARE;
                        end
                        CMD_READ: begin
                            o_ctl.rd_start = 1'b1;
                            n_state        = ST_READ;
                        end
                        default: ; // unused code: word taken, nothing produced
                    endcase
                end
            end
            ST_SQUARE: begin
                o_ctl.square = 1'b1;
                n_state      = ST_INSERT;
            end
            ST_INSERT: begin
                o_ctl.insert = 1'b1;
                n_state      = ST_RANGE;
            end
            ST_RANGE: begin
                o_ctl.range_upd = 1'b1;
                n_state         = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctl.emit_status = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_READ: begin
                if (i_stat.out_free) begin
                    o_ctl.emit_entry = 1'b1;
                    if (i_stat.list_empty || i_stat.rd_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
